@@ hdl/lmrd_pkg.sv @@
// Shared types and constants for the lane marking row detector.
// No dependencies; lmrd_peak and the top level refer to this package by scoped names.
package lmrd_pkg;

   localparam int MAX_COLS        = 1024;
   localparam int MAX_HALF_WINDOW = 15;
   localparam int ADDR_W          = $clog2(MAX_COLS);
   localparam int CNT_W           = ADDR_W + 1;
   localparam int SIDX_W          = CNT_W + 1;
   localparam int PIX_W           = 8;
   localparam int KW_W            = 4;
   localparam int CSR_W           = 8;
   localparam int CSR_IDX_W       = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIFF    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_WINDOW = 1'd1;

   localparam logic [PIX_W-1:0] MIN_DIFF_RESET    = 8'd10;
   localparam logic [KW_W-1:0]  PEAK_WINDOW_RESET = 4'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic             operation;
      logic [PIX_W-1:0] gray;
      logic             object_flag;
      logic             last_in_row;
   } lmrd_req_type;

   typedef struct packed {
      logic lane_flag;
      logic last_of_row;
   } lmrd_rsp_type;

   // pixel memory word: pixel, mask bit and the lane mark written back by the scan
   typedef struct packed {
      logic [PIX_W-1:0] gray;
      logic             obj;
      logic             lane;
   } lmrd_aword_type;

   // edge memory word: responses and the nearest edges at or after the column
   typedef struct packed {
      logic [PIX_W-1:0]  rise;
      logic [PIX_W-1:0]  fall;
      logic              nr_v;
      logic [ADDR_W-1:0] nr;
      logic              nf_v;
      logic [ADDR_W-1:0] nf;
   } lmrd_bword_type;

   typedef struct packed {
      logic [ADDR_W-1:0] raddr;
      logic              we;
      logic [ADDR_W-1:0] waddr;
      lmrd_bword_type    wdata;
   } lmrd_bport_type;

endpackage

@@ hdl/lmrd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lmrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
      rd_data_ff <= mem[read_addr];
   end

   assign read_data = rd_data_ff;

endmodule

@@ hdl/lmrd_peak.sv @@
// Sliding-window peak suppression sequencer over one channel of the edge memory.
// Depends on lmrd_pkg; drives the edge memory port through lmrd_bport_type.
module lmrd_peak (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          sel,
   input  logic [lmrd_pkg::CNT_W-1:0]    half_win,
   input  logic [lmrd_pkg::CNT_W-1:0]    row_len,
   input  lmrd_pkg::lmrd_bword_type      rdata,
   output lmrd_pkg::lmrd_bport_type      port,
   output logic                          done
);

   localparam logic [2:0] P_IDLE     = 3'd0;
   localparam logic [2:0] P_DECIDE   = 3'd1;
   localparam logic [2:0] P_SCAN_RD  = 3'd2;
   localparam logic [2:0] P_SCAN_USE = 3'd3;
   localparam logic [2:0] P_EXT_RD   = 3'd4;
   localparam logic [2:0] P_EXT_USE  = 3'd5;
   localparam logic [2:0] P_VC_RD    = 3'd6;
   localparam logic [2:0] P_VC_USE   = 3'd7;

   logic [2:0]                      state_ff, state_in;
   logic [lmrd_pkg::CNT_W-1:0]      col_ff, col_in;
   logic [lmrd_pkg::CNT_W-1:0]      midx_ff, midx_in;
   logic [lmrd_pkg::CNT_W-1:0]      scan_ff, scan_in;
   logic [lmrd_pkg::PIX_W-1:0]      mval_ff, mval_in;
   logic                            first_ff, first_in;
   logic                            sfirst_ff, sfirst_in;
   logic [lmrd_pkg::PIX_W-1:0]      val;
   logic [lmrd_pkg::CNT_W-1:0]      win_lo;
   logic [lmrd_pkg::CNT_W-1:0]      win_hi;
   lmrd_pkg::lmrd_bword_type        zeroed;

   assign val    = sel ? rdata.fall : rdata.rise;
   assign win_lo = col_ff - half_win;
   assign win_hi = col_ff + half_win;

   always_comb begin
      zeroed = rdata;
      if (sel) begin
         zeroed.fall = '0;
      end else begin
         zeroed.rise = '0;
      end
   end

   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      midx_in    = midx_ff;
      scan_in    = scan_ff;
      mval_in    = mval_ff;
      first_in   = first_ff;
      sfirst_in  = sfirst_ff;
      done       = 1'b0;
      port.raddr = col_ff[lmrd_pkg::ADDR_W-1:0];
      port.we    = 1'b0;
      port.waddr = col_ff[lmrd_pkg::ADDR_W-1:0];
      port.wdata = zeroed;
      case (state_ff)
         P_IDLE: begin
            if (start) begin
               col_in   = half_win;
               first_in = 1'b1;
               state_in = P_DECIDE;
            end
         end
         P_DECIDE: begin
            if (win_hi >= row_len) begin
               done     = 1'b1;
               state_in = P_IDLE;
            end else if (first_ff || (midx_ff < win_lo)) begin
               // first window, or window max fell out on the left: rescan the whole window
               scan_in   = win_lo;
               midx_in   = win_lo;
               sfirst_in = 1'b1;
               state_in  = P_SCAN_RD;
            end else begin
               state_in = P_EXT_RD;
            end
         end
         P_SCAN_RD: begin
            port.raddr = scan_ff[lmrd_pkg::ADDR_W-1:0];
            state_in   = P_SCAN_USE;
         end
         P_SCAN_USE: begin
            first_in  = 1'b0;
            sfirst_in = 1'b0;
            if (sfirst_ff || (val > mval_ff)) begin
               mval_in = val;
               midx_in = scan_ff;
            end
            if (scan_ff == win_hi) begin
               state_in = P_VC_RD;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = P_SCAN_RD;
            end
         end
         P_EXT_RD: begin
            port.raddr = win_hi[lmrd_pkg::ADDR_W-1:0];
            state_in   = P_EXT_USE;
         end
         P_EXT_USE: begin
            if (val > mval_ff) begin
               mval_in = val;
               midx_in = win_hi;
            end
            state_in = P_VC_RD;
         end
         P_VC_RD: begin
            state_in = P_VC_USE;
         end
         P_VC_USE: begin
            // drop a response that is not the window maximum
            port.we  = (val != mval_ff);
            col_in   = col_ff + 1'b1;
            state_in = P_DECIDE;
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
      col_ff    <= col_in;
      midx_ff   <= midx_in;
      scan_ff   <= scan_in;
      mval_ff   <= mval_in;
      first_ff  <= first_in;
      sfirst_ff <= sfirst_in;
   end

endmodule

@@ hdl/lane_marking_row_detector_unit.sv @@
// Top level of the lane marking row detector: request handling and row passes.
// Depends on lmrd_pkg, lmrd_ram (pixel and edge memories) and lmrd_peak.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  lmrd_req_type
//   rsp_      out        rsp_valid / rsp_stall  lmrd_rsp_type
//   csr_      in         csr_write_en           csr_index, csr_wdata
//
// The final load of a row is followed by streaming passes over the memories
// (gradient, next-edge sweep right to left, lane scan) plus the peak
// suppression sequencer, which works on the edge memory port for each
// channel in turn. A read is answered through the registered memory read.
// No clearing pass follows reset. A waiting result stalls only further reads.
module lane_marking_row_detector_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  lmrd_pkg::lmrd_req_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output lmrd_pkg::lmrd_rsp_type          rsp_data,
   input  logic                            csr_write_en,
   input  logic [lmrd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lmrd_pkg::CSR_W-1:0]      csr_wdata
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_RD_WAIT = 3'd1;
   localparam logic [2:0] S_GRAD    = 3'd2;
   localparam logic [2:0] S_PEAK_R  = 3'd3;
   localparam logic [2:0] S_PEAK_F  = 3'd4;
   localparam logic [2:0] S_BACK    = 3'd5;
   localparam logic [2:0] S_FWD     = 3'd6;

   localparam int CW = lmrd_pkg::CNT_W;
   localparam int AW = lmrd_pkg::ADDR_W;
   localparam int SW = lmrd_pkg::SIDX_W;
   localparam int PW = lmrd_pkg::PIX_W;

   localparam logic signed [SW-1:0] S_ONE     = SW'(1);
   localparam logic signed [SW-1:0] S_NEG_ONE = SW'(-1);

   logic [2:0]                  state_ff, state_in;
   logic [PW-1:0]               min_diff_ff;
   logic [lmrd_pkg::KW_W-1:0]   peak_window_ff;
   logic [CW-1:0]               load_count_ff, load_count_in;
   logic [CW-1:0]               row_length_ff, row_length_in;
   logic [CW-1:0]               read_index_ff, read_index_in;
   logic                        reading_ff, reading_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   lmrd_pkg::lmrd_rsp_type      rsp_data_ff, rsp_data_in;
   logic                        last_ff, last_in;
   logic [CW-1:0]               ptr_ff, ptr_in;
   logic                        pv_ff, pv_in;
   logic [AW-1:0]               pa_ff, pa_in;
   logic [PW-1:0]               prev_ff, prev_in;
   logic                        nr_v_ff, nr_v_in;
   logic [AW-1:0]               nr_ff, nr_in;
   logic                        nf_v_ff, nf_v_in;
   logic [AW-1:0]               nf_ff, nf_in;
   logic signed [SW-1:0]        lr_ff, lr_in;
   logic signed [SW-1:0]        lf_ff, lf_in;
   logic                        peak_start_ff, peak_start_in;

   logic                        accept;
   logic [CW-1:0]               cnt_base;
   logic                        room;
   logic [CW-1:0]               cnt_next;
   logic [CW-1:0]               half_win;
   logic [CW-1:0]               win_len;
   logic                        skip_peak;
   logic                        issue;
   logic [CW-1:0]               pass_idx;
   logic [AW-1:0]               pass_addr;

   logic                        a_we;
   logic [AW-1:0]               a_waddr;
   lmrd_pkg::lmrd_aword_type    a_wdata;
   logic [AW-1:0]               a_raddr;
   logic [$bits(lmrd_pkg::lmrd_aword_type)-1:0] a_rbits;
   lmrd_pkg::lmrd_aword_type    a_rword;

   logic                        b_we;
   logic [AW-1:0]               b_waddr;
   lmrd_pkg::lmrd_bword_type    b_wdata;
   logic [AW-1:0]               b_raddr;
   logic [$bits(lmrd_pkg::lmrd_bword_type)-1:0] b_rbits;
   lmrd_pkg::lmrd_bword_type    b_rword;

   lmrd_pkg::lmrd_bport_type    peak_port;
   logic                        peak_done;
   logic                        peak_sel;

   logic [PW-1:0]               rise_raw, fall_raw;
   logic [PW-1:0]               rise_val, fall_val;
   logic signed [SW-1:0]        col_s;
   logic signed [SW-1:0]        rr;
   logic signed [SW-1:0]        rf;
   logic                        lane;

   assign a_rword = lmrd_pkg::lmrd_aword_type'(a_rbits);
   assign b_rword = lmrd_pkg::lmrd_bword_type'(b_rbits);

   assign req_stall = (state_ff != S_IDLE) ||
                      ((req_data.operation == lmrd_pkg::OP_READ) && rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cnt_base  = reading_ff ? '0 : load_count_ff;
   assign room      = cnt_base < CW'(lmrd_pkg::MAX_COLS);
   assign cnt_next  = cnt_base + CW'(room);

   assign half_win  = (CW'(peak_window_ff) > CW'(lmrd_pkg::MAX_HALF_WINDOW)) ?
                      CW'(lmrd_pkg::MAX_HALF_WINDOW) : CW'(peak_window_ff);
   assign win_len   = (half_win << 1) + 1'b1;
   // a window of one keeps every response
   assign skip_peak = (half_win == '0) || (row_length_ff < win_len);

   assign issue     = ptr_ff < row_length_ff;
   assign pass_idx  = (state_ff == S_BACK) ? (row_length_ff - 1'b1 - ptr_ff) : ptr_ff;
   assign pass_addr = pass_idx[AW-1:0];
   assign peak_sel  = (state_ff == S_PEAK_F);

   // gradient of the pending pixel against the previous one
   always_comb begin
      rise_raw = '0;
      fall_raw = '0;
      if (pa_ff != '0) begin
         if (a_rword.gray > prev_ff) begin
            rise_raw = a_rword.gray - prev_ff;
         end
         if (prev_ff > a_rword.gray) begin
            fall_raw = prev_ff - a_rword.gray;
         end
      end
      rise_val = (rise_raw > min_diff_ff) ? rise_raw : '0;
      fall_val = (fall_raw > min_diff_ff) ? fall_raw : '0;
   end

   // lane decision for the pending column of the scan
   always_comb begin
      col_s = SW'(signed'({2'b00, pa_ff}));
      lr_in = (b_rword.rise != '0) ? (col_s - S_ONE) : lr_ff;
      lf_in = (b_rword.fall != '0) ? col_s : lf_ff;
      rr    = b_rword.nr_v ? (SW'(signed'({2'b00, b_rword.nr})) - S_ONE) : S_NEG_ONE;
      rf    = SW'(signed'({2'b00, b_rword.nf}));
      lane  = a_rword.obj && (lr_in > lf_in) && b_rword.nf_v &&
              ((rr == S_NEG_ONE) || (rr > rf));
   end

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      row_length_in = row_length_ff;
      read_index_in = read_index_ff;
      reading_in    = reading_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      last_in       = last_ff;
      ptr_in        = ptr_ff;
      pv_in         = 1'b0;
      pa_in         = pass_addr;
      prev_in       = prev_ff;
      nr_v_in       = nr_v_ff;
      nr_in         = nr_ff;
      nf_v_in       = nf_v_ff;
      nf_in         = nf_ff;
      peak_start_in = 1'b0;

      a_we          = 1'b0;
      a_waddr       = cnt_base[AW-1:0];
      a_wdata.gray  = req_data.gray;
      a_wdata.obj   = req_data.object_flag;
      a_wdata.lane  = 1'b0;
      a_raddr       = pass_addr;
      b_we          = 1'b0;
      b_waddr       = pa_ff;
      b_wdata       = b_rword;
      b_raddr       = pass_addr;

      case (state_ff)
         S_IDLE: begin
            a_raddr = read_index_ff[AW-1:0];
            if (accept && (req_data.operation == lmrd_pkg::OP_LOAD)) begin
               a_we = room;
               if (req_data.last_in_row) begin
                  row_length_in = cnt_next;
                  load_count_in = '0;
                  read_index_in = '0;
                  reading_in    = 1'b1;
                  ptr_in        = '0;
                  state_in      = S_GRAD;
               end else begin
                  load_count_in = cnt_next;
                  reading_in    = 1'b0;
                  if (reading_ff) begin
                     read_index_in = '0;
                  end
               end
            end else if (accept && reading_ff && (read_index_ff < row_length_ff)) begin
               last_in       = (read_index_ff + 1'b1) == row_length_ff;
               read_index_in = read_index_ff + 1'b1;
               if ((read_index_ff + 1'b1) == row_length_ff) begin
                  reading_in = 1'b0;
               end
               state_in = S_RD_WAIT;
            end
         end
         S_RD_WAIT: begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.lane_flag   = a_rword.lane;
            rsp_data_in.last_of_row = last_ff;
            state_in                = S_IDLE;
         end
         S_GRAD: begin
            pv_in  = issue;
            ptr_in = ptr_ff + CW'(issue);
            if (pv_ff) begin
               b_we         = 1'b1;
               b_wdata      = '0;
               b_wdata.rise = rise_val;
               b_wdata.fall = fall_val;
               prev_in      = a_rword.gray;
            end
            if (!issue && !pv_ff) begin
               ptr_in = '0;
               if (skip_peak) begin
                  nr_v_in  = 1'b0;
                  nf_v_in  = 1'b0;
                  state_in = S_BACK;
               end else begin
                  peak_start_in = 1'b1;
                  state_in      = S_PEAK_R;
               end
            end
         end
         S_PEAK_R, S_PEAK_F: begin
            b_raddr = peak_port.raddr;
            b_we    = peak_port.we;
            b_waddr = peak_port.waddr;
            b_wdata = peak_port.wdata;
            if (peak_done) begin
               if (state_ff == S_PEAK_R) begin
                  peak_start_in = 1'b1;
                  state_in      = S_PEAK_F;
               end else begin
                  nr_v_in  = 1'b0;
                  nf_v_in  = 1'b0;
                  state_in = S_BACK;
               end
            end
         end
         S_BACK: begin
            // sweep right to left, carry the nearest edges at or after each column
            pv_in  = issue;
            ptr_in = ptr_ff + CW'(issue);
            if (pv_ff) begin
               if (b_rword.rise != '0) begin
                  nr_v_in = 1'b1;
                  nr_in   = pa_ff;
               end
               if (b_rword.fall != '0) begin
                  nf_v_in = 1'b1;
                  nf_in   = pa_ff;
               end
               b_we         = 1'b1;
               b_wdata.nr_v = nr_v_in;
               b_wdata.nr   = nr_in;
               b_wdata.nf_v = nf_v_in;
               b_wdata.nf   = nf_in;
            end
            if (!issue && !pv_ff) begin
               ptr_in   = '0;
               state_in = S_FWD;
            end
         end
         S_FWD: begin
            pv_in  = issue;
            ptr_in = ptr_ff + CW'(issue);
            if (pv_ff) begin
               a_we         = 1'b1;
               a_waddr      = pa_ff;
               a_wdata.gray = a_rword.gray;
               a_wdata.obj  = a_rword.obj;
               a_wdata.lane = lane;
            end
            if (!issue && !pv_ff) begin
               ptr_in   = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         min_diff_ff    <= lmrd_pkg::MIN_DIFF_RESET;
         peak_window_ff <= lmrd_pkg::PEAK_WINDOW_RESET;
         load_count_ff  <= '0;
         row_length_ff  <= '0;
         read_index_ff  <= '0;
         reading_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pv_ff          <= 1'b0;
         ptr_ff         <= '0;
         peak_start_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         row_length_ff <= row_length_in;
         read_index_ff <= read_index_in;
         reading_ff    <= reading_in;
         rsp_valid_ff  <= rsp_valid_in;
         pv_ff         <= pv_in;
         ptr_ff        <= ptr_in;
         peak_start_ff <= peak_start_in;
         if (csr_write_en && (csr_index == lmrd_pkg::CSR_MIN_DIFF)) begin
            min_diff_ff <= csr_wdata;
         end
         if (csr_write_en && (csr_index == lmrd_pkg::CSR_PEAK_WINDOW)) begin
            peak_window_ff <= csr_wdata[lmrd_pkg::KW_W-1:0];
         end
      end
      rsp_data_ff <= rsp_data_in;
      last_ff     <= last_in;
      pa_ff       <= pa_in;
      prev_ff     <= prev_in;
      nr_v_ff     <= nr_v_in;
      nr_ff       <= nr_in;
      nf_v_ff     <= nf_v_in;
      nf_ff       <= nf_in;
      if (state_ff != S_FWD) begin
         lr_ff <= '0;
         lf_ff <= '0;
      end else if (pv_ff) begin
         lr_ff <= lr_in;
         lf_ff <= lf_in;
      end
   end

   lmrd_ram #(
      .WIDTH($bits(lmrd_pkg::lmrd_aword_type)),
      .DEPTH(lmrd_pkg::MAX_COLS)
   ) u_pixel_ram (
      .clock      (clock),
      .write_en   (a_we),
      .write_addr (a_waddr),
      .write_data (a_wdata),
      .read_addr  (a_raddr),
      .read_data  (a_rbits)
   );

   lmrd_ram #(
      .WIDTH($bits(lmrd_pkg::lmrd_bword_type)),
      .DEPTH(lmrd_pkg::MAX_COLS)
   ) u_edge_ram (
      .clock      (clock),
      .write_en   (b_we),
      .write_addr (b_waddr),
      .write_data (b_wdata),
      .read_addr  (b_raddr),
      .read_data  (b_rbits)
   );

   lmrd_peak u_peak (
      .clock    (clock),
      .reset    (reset),
      .start    (peak_start_ff),
      .sel      (peak_sel),
      .half_win (half_win),
      .row_len  (row_length_ff),
      .rdata    (b_rword),
      .port     (peak_port),
      .done     (peak_done)
   );

`ifndef NO_ASSERTIONS
   a_rd_wait_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD_WAIT) |=> rsp_valid_ff)
      else $error("read did not produce a response");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == S_IDLE))
      else $error("request accepted during a row pass");

   a_read_index_bound: assert property (@(posedge clock) disable iff (reset)
      read_index_ff <= row_length_ff)
      else $error("read index past row length");

   a_load_count_bound: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= CW'(lmrd_pkg::MAX_COLS))
      else $error("load count past row capacity");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pv_ff)
      else $error("pass pipeline busy while idle");
`endif

endmodule
